// ----- src/izpp_pkg.sv -----
`default_nettype none
package izpp_pkg;

   localparam int DEPTH_ENTRIES = 16384;
   localparam int TEXEL_ENTRIES = 4096;
   localparam int SHADE_ENTRIES = 16384;
   localparam int SHADE_ROW_LEN = 256;
   localparam int ADDR_W = 14;
   localparam int TEX_ADDR_W = 12;
   localparam int DEF_SCREEN_W = 128;
   localparam int DEF_SCREEN_H = 128;
   localparam int DEF_TEX_PITCH = 64;
   localparam int DEF_SHADE_ROWS = 64;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_PLOT = 2'd0,
      CMD_LOAD_TEXEL = 2'd1,
      CMD_LOAD_SHADE = 2'd2,
      CMD_CLEAR_DEPTH = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_RENDER_MODE = 2'd0,
      CSR_TEX_WIDTH = 2'd1,
      CSR_TEX_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_FLAT = 2'd0,
      MODE_TEXTURED = 2'd1,
      MODE_LIT = 2'd2,
      MODE_LIT_ALT = 2'd3
   } mode_type;

   typedef struct packed {
      cmd_type cmd;
      logic [ADDR_W-1:0] pix;
      logic [15:0] depth;
      logic [7:0] inten;
      logic [7:0] row;
      logic [5:0] u_int;
      logic [5:0] v_int;
      logic [ADDR_W-1:0] load_address;
      logic [7:0] load_data;
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_TEST,
      ST_SHADE,
      ST_OUT
   } back_state_type;

endpackage
`default_nettype wire

// ----- src/izpp_front.sv -----
`default_nettype none
module izpp_front #(
   parameter int SCREEN_W = izpp_pkg::DEF_SCREEN_W,
   parameter int SCREEN_H = izpp_pkg::DEF_SCREEN_H,
   parameter int SHADE_ROWS = izpp_pkg::DEF_SHADE_ROWS
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire logic [izpp_pkg::REQ_DATA_W-1:0] in_data,
   input wire logic [6:0] tex_width,
   input wire logic [6:0] tex_height,
   output logic out_valid,
   input wire logic out_ready,
   output izpp_pkg::op_type out_op
);
   import izpp_pkg::*;

   localparam int XW = $clog2(SCREEN_W);
   localparam int YW = $clog2(SCREEN_H);

   // reduce the integer parts of u and v four bits per cycle, MSB first
   logic busy_ff, busy_in;
   logic [2:0] step_ff, step_in;
   op_type op_ff, op_in;
   logic [15:0] u_mag_ff, u_mag_in, v_mag_ff, v_mag_in;
   logic u_neg_ff, u_neg_in, v_neg_ff, v_neg_in;
   logic [6:0] u_rem_ff, u_rem_in, v_rem_ff, v_rem_in;
   logic [6:0] w_ff, w_in, h_ff, h_in;
   logic [6:0] u_fix, v_fix;
   logic done;

   logic [1:0] f_cmd;
   logic signed [11:0] f_x, f_y;
   logic [15:0] f_depth;
   logic [7:0] f_int;
   logic [15:0] f_ui, f_vi;
   logic [ADDR_W-1:0] f_la;
   logic [7:0] f_ld;
   logic [XW-1:0] cx;
   logic [YW-1:0] cy;
   logic [ADDR_W-1:0] pix;
   logic [7:0] row;
   logic [6:0] w_eff, h_eff;

   function automatic logic [6:0] rem_step(logic [6:0] rem, logic [3:0] bits,
                                          logic [6:0] size);
      logic [7:0] acc;
      acc = {1'b0, rem};
      for (int i = 3; i >= 0; i--) begin
         acc = {acc[6:0], bits[i]};
         if (acc >= {1'b0, size}) acc = acc - {1'b0, size};
      end
      return acc[6:0];
   endfunction

   assign f_cmd = in_data[1:0];
   assign f_x = in_data[13:2];
   assign f_y = in_data[25:14];
   assign f_depth = in_data[41:26];
   assign f_int = in_data[49:42];
   assign f_ui = in_data[81:66];
   assign f_vi = in_data[113:98];
   assign f_la = in_data[127:114];
   assign f_ld = in_data[135:128];

   always_comb begin
      if (f_x < 0) cx = '0;
      else if (32'(f_x) > SCREEN_W - 1) cx = XW'(SCREEN_W - 1);
      else cx = XW'(f_x);
      if (f_y < 0) cy = '0;
      else if (32'(f_y) > SCREEN_H - 1) cy = YW'(SCREEN_H - 1);
      else cy = YW'(f_y);
      pix = ADDR_W'(32'(cy) * SCREEN_W + 32'(cx));
      row = (32'(f_int) > SHADE_ROWS - 1) ? 8'(SHADE_ROWS - 1) : f_int;
      w_eff = (tex_width == 0) ? 7'd1 : (tex_width > 64) ? 7'd64 : tex_width;
      h_eff = (tex_height == 0) ? 7'd1 : (tex_height > 64) ? 7'd64 : tex_height;
   end

   assign in_ready = !busy_ff;
   assign done = busy_ff && (step_ff == 3'd4);
   assign out_valid = done;
   assign u_fix = (u_neg_ff && u_rem_ff != 7'd0) ? w_ff - u_rem_ff : u_rem_ff;
   assign v_fix = (v_neg_ff && v_rem_ff != 7'd0) ? h_ff - v_rem_ff : v_rem_ff;

   always_comb begin
      out_op = op_ff;
      out_op.u_int = u_fix[5:0];
      out_op.v_int = v_fix[5:0];
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      op_in = op_ff;
      u_mag_in = u_mag_ff;
      v_mag_in = v_mag_ff;
      u_neg_in = u_neg_ff;
      v_neg_in = v_neg_ff;
      u_rem_in = u_rem_ff;
      v_rem_in = v_rem_ff;
      w_in = w_ff;
      h_in = h_ff;
      if (!busy_ff) begin
         if (in_valid) begin
            busy_in = 1'b1;
            step_in = '0;
            op_in.cmd = cmd_type'(f_cmd);
            op_in.pix = pix;
            op_in.depth = f_depth;
            op_in.inten = f_int;
            op_in.row = row;
            op_in.u_int = '0;
            op_in.v_int = '0;
            op_in.load_address = f_la;
            op_in.load_data = f_ld;
            u_neg_in = f_ui[15];
            v_neg_in = f_vi[15];
            u_mag_in = f_ui[15] ? (16'd0 - f_ui) : f_ui;
            v_mag_in = f_vi[15] ? (16'd0 - f_vi) : f_vi;
            u_rem_in = '0;
            v_rem_in = '0;
            w_in = w_eff;
            h_in = h_eff;
         end
      end else if (!done) begin
         step_in = step_ff + 3'd1;
         u_rem_in = rem_step(u_rem_ff, u_mag_ff[15:12], w_ff);
         v_rem_in = rem_step(v_rem_ff, v_mag_ff[15:12], h_ff);
         u_mag_in = {u_mag_ff[11:0], 4'd0};
         v_mag_in = {v_mag_ff[11:0], 4'd0};
      end else if (out_ready) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      op_ff <= op_in;
      u_mag_ff <= u_mag_in;
      v_mag_ff <= v_mag_in;
      u_neg_ff <= u_neg_in;
      v_neg_ff <= v_neg_in;
      u_rem_ff <= u_rem_in;
      v_rem_ff <= v_rem_in;
      w_ff <= w_in;
      h_ff <= h_in;
   end

endmodule
`default_nettype wire

// ----- src/izpp_queue.sv -----
`default_nettype none
module izpp_queue (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire izpp_pkg::op_type in_op,
   output logic out_valid,
   input wire logic out_ready,
   output izpp_pkg::op_type out_op
);
   import izpp_pkg::*;

   op_type mem_ff [QUEUE_DEPTH];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready = cnt_ff != 2'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != 2'd0;
   assign out_op = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_op;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(QUEUE_DEPTH))
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count lost a push");
   assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("queue count lost a pop");

endmodule
`default_nettype wire

// ----- src/izpp_back.sv -----
`default_nettype none
module izpp_back #(
   parameter int TEX_PITCH = izpp_pkg::DEF_TEX_PITCH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire izpp_pkg::op_type in_op,
   input wire logic [1:0] mode,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [izpp_pkg::RSP_DATA_W-1:0] rsp_data
);
   import izpp_pkg::*;

   logic [15:0] depth_mem [DEPTH_ENTRIES];
   logic [7:0] texel_mem [TEXEL_ENTRIES];
   logic [7:0] shade_mem [SHADE_ENTRIES];

   back_state_type state_ff, state_in;
   op_type op_ff, op_in;
   logic [15:0] zrd_ff;
   logic [7:0] trd_ff, srd_ff;
   logic wv_ff, wv_in;
   logic [ADDR_W-1:0] pa_ff, pa_in;
   logic [7:0] col_ff, col_in;
   logic zwr, take;
   logic [TEX_ADDR_W-1:0] tidx;
   logic [ADDR_W-1:0] sidx;

   assign tidx = TEX_ADDR_W'(32'(op_ff.v_int) * TEX_PITCH + 32'(op_ff.u_int));
   assign sidx = ADDR_W'({op_ff.row, trd_ff});
   assign in_ready = state_ff == ST_IDLE;
   assign take = in_valid && in_ready;
   assign rsp_valid = state_ff == ST_OUT;
   assign rsp_data = {1'b0, col_ff, pa_ff, wv_ff};

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      wv_in = wv_ff;
      pa_in = pa_ff;
      col_in = col_ff;
      zwr = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               op_in = in_op;
               wv_in = 1'b0;
               pa_in = '0;
               col_in = '0;
               state_in = (in_op.cmd == CMD_PLOT) ? ST_READ : ST_OUT;
            end
         end
         ST_READ: state_in = ST_TEST;
         ST_TEST: begin
            pa_in = op_ff.pix;
            if (!(zrd_ff > op_ff.depth)) begin
               state_in = ST_OUT;
            end else if (mode == MODE_FLAT) begin
               wv_in = 1'b1;
               col_in = op_ff.inten;
               zwr = 1'b1;
               state_in = ST_OUT;
            end else if (trd_ff == 8'd0) begin
               state_in = ST_OUT;
            end else if (mode inside {MODE_LIT, MODE_LIT_ALT}) begin
               state_in = ST_SHADE;
            end else begin
               wv_in = 1'b1;
               col_in = trd_ff;
               zwr = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_SHADE: begin
            wv_in = 1'b1;
            col_in = srd_ff;
            zwr = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      op_ff <= op_in;
      wv_ff <= wv_in;
      pa_ff <= pa_in;
      col_ff <= col_in;
   end

   always_ff @(posedge clock) begin
      if (take && in_op.cmd == CMD_CLEAR_DEPTH) depth_mem[in_op.load_address] <= 16'hFFFF;
      else if (zwr) depth_mem[op_ff.pix] <= op_ff.depth;
      zrd_ff <= depth_mem[op_ff.pix];
   end

   always_ff @(posedge clock) begin
      if (take && in_op.cmd == CMD_LOAD_TEXEL)
         texel_mem[in_op.load_address[TEX_ADDR_W-1:0]] <= in_op.load_data;
      trd_ff <= texel_mem[tidx];
   end

   always_ff @(posedge clock) begin
      if (take && in_op.cmd == CMD_LOAD_SHADE) shade_mem[in_op.load_address] <= in_op.load_data;
      srd_ff <= shade_mem[sidx];
   end

   assert property (@(posedge clock) disable iff (reset) zwr |-> state_in == ST_OUT)
      else $error("depth write without result");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset) wv_ff && rsp_valid |-> op_ff.cmd == CMD_PLOT)
      else $error("write from non-plot command");

endmodule
`default_nettype wire

// ----- src/indexed_zbuffer_point_plotter_core.sv -----
`default_nettype none
// Depth-tested indexed point plotter. Each transaction gives one result. The front
// clamps the point and wraps the integer parts of u and v by a serial remainder of
// four bits per cycle; it takes no new transaction until it has reduced the last one
// and handed it off to the two-entry queue. The back does the depth read, texel read
// and optional shade read for plots, while load and clear commands skip the reads
// and go straight to the result. A held result stalls the back, then the queue,
// then the input. Depth, texel and shade memories are undefined until loaded or
// cleared by command.
module indexed_zbuffer_point_plotter_core #(
   parameter int SCREEN_W = izpp_pkg::DEF_SCREEN_W,
   parameter int SCREEN_H = izpp_pkg::DEF_SCREEN_H,
   parameter int TEX_PITCH = izpp_pkg::DEF_TEX_PITCH,
   parameter int SHADE_ROWS = izpp_pkg::DEF_SHADE_ROWS
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // cmd, pos_x, pos_y, depth, intensity, tex_u, tex_v, load_address, load_data
   input wire logic [izpp_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // write_valid, pixel_address, colour_index
   output logic [izpp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [izpp_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [izpp_pkg::CSR_DATA_W-1:0] csr_data
);
   import izpp_pkg::*;

   logic [1:0] mode_ff;
   logic [6:0] tw_ff, th_ff;
   logic fq_valid, fq_ready, qb_valid, qb_ready;
   op_type fq_op, qb_op;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FLAT;
         tw_ff <= 7'd64;
         th_ff <= 7'd64;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_RENDER_MODE: mode_ff <= csr_data[1:0];
            CSR_TEX_WIDTH: tw_ff <= csr_data[6:0];
            CSR_TEX_HEIGHT: th_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   izpp_front #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H), .SHADE_ROWS(SHADE_ROWS)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(req_tdata),
      .tex_width(tw_ff), .tex_height(th_ff),
      .out_valid(fq_valid), .out_ready(fq_ready), .out_op(fq_op)
   );

   izpp_queue u_queue (
      .clock, .reset,
      .in_valid(fq_valid), .in_ready(fq_ready), .in_op(fq_op),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_op(qb_op)
   );

   izpp_back #(.TEX_PITCH(TEX_PITCH)) u_back (
      .clock, .reset,
      .in_valid(qb_valid), .in_ready(qb_ready), .in_op(qb_op), .mode(mode_ff),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_data(rsp_tdata)
   );

endmodule
`default_nettype wire

// ----- verif/indexed_zbuffer_point_plotter_core_tb.sv -----
`timescale 1ns / 1ps
module indexed_zbuffer_point_plotter_core_tb;
   import izpp_pkg::*;

   localparam int SCR_W = 128;
   localparam int SCR_H = 128;
   localparam int PITCH = 64;
   localparam int SH_ROWS = 64;

   typedef struct {
      cmd_type cmd;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [15:0] depth;
      logic [7:0] inten;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
      logic [13:0] load_addr;
      logic [7:0] load_data;
   } point_op_t;

   typedef struct {
      logic wv;
      logic [13:0] pix;
      logic [7:0] colour;
   } pixel_write_t;

   typedef struct {
      logic [1:0] mode;
      logic [6:0] tw;
      logic [6:0] th;
      point_op_t op;
      bit typed;
      pixel_write_t want;
   } dir_row_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic [15:0] depth_mem [DEPTH_ENTRIES];
   logic [7:0] texel_mem [TEXEL_ENTRIES];
   logic [7:0] shade_mem [SHADE_ENTRIES];
   bit depth_known [DEPTH_ENTRIES];
   bit texel_known [TEXEL_ENTRIES];
   bit shade_known [SHADE_ENTRIES];
   logic [1:0] cur_mode = MODE_FLAT;
   logic [6:0] cur_tw = 7'd64;
   logic [6:0] cur_th = 7'd64;

   pixel_write_t pending_writes [$];
   dir_row_t rows [$];
   int errors = 0;
   int send_idle = 0;
   int stall_pct = 0;
   bit hold = 0;
   bit hold_go = 0;

   indexed_zbuffer_point_plotter_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic int tex_size(logic [6:0] r);
      if (r < 1) return 1;
      if (r > 64) return 64;
      return r;
   endfunction

   function automatic int wrap_coord(logic signed [31:0] c, int size);
      longint m;
      longint r;
      m = longint'(size) * 65536;
      r = longint'(c) % m;
      if (r < 0) r += m;
      return int'(r / 65536);
   endfunction

   function automatic logic [13:0] pixel_of(point_op_t op);
      int x;
      int y;
      x = op.pos_x < 0 ? 0 : (op.pos_x > SCR_W - 1 ? SCR_W - 1 : int'(op.pos_x));
      y = op.pos_y < 0 ? 0 : (op.pos_y > SCR_H - 1 ? SCR_H - 1 : int'(op.pos_y));
      return 14'(y * SCR_W + x);
   endfunction

   function automatic logic [11:0] texel_of(point_op_t op);
      int ui;
      int vi;
      ui = wrap_coord(op.tex_u, tex_size(cur_tw));
      vi = wrap_coord(op.tex_v, tex_size(cur_th));
      return 12'(vi * PITCH + ui);
   endfunction

   function automatic logic [13:0] shade_of(point_op_t op, logic [7:0] texel);
      int row;
      row = op.inten > SH_ROWS - 1 ? SH_ROWS - 1 : int'(op.inten);
      return 14'(row * SHADE_ROW_LEN + texel);
   endfunction

   // compute the pixel write and advance the store copies
   function automatic pixel_write_t plot_point(point_op_t op);
      pixel_write_t w;
      logic [13:0] pix;
      logic [7:0] texel;
      w = '{1'b0, 14'd0, 8'd0};
      case (op.cmd)
         CMD_LOAD_TEXEL: begin
            texel_mem[op.load_addr[11:0]] = op.load_data;
            texel_known[op.load_addr[11:0]] = 1;
         end
         CMD_LOAD_SHADE: begin
            shade_mem[op.load_addr] = op.load_data;
            shade_known[op.load_addr] = 1;
         end
         CMD_CLEAR_DEPTH: begin
            depth_mem[op.load_addr] = 16'hFFFF;
            depth_known[op.load_addr] = 1;
         end
         default: begin
            pix = pixel_of(op);
            w.pix = pix;
            if (depth_mem[pix] <= op.depth) return w;
            if (cur_mode == MODE_FLAT) begin
               w.colour = op.inten;
            end else begin
               texel = texel_mem[texel_of(op)];
               if (texel == 0) return w;
               w.colour = cur_mode[1] ? shade_mem[shade_of(op, texel)] : texel;
            end
            depth_mem[pix] = op.depth;
            w.wv = 1;
         end
      endcase
      return w;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= !hold && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      pixel_write_t got;
      pixel_write_t want;
      bit bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.wv = rsp_tdata[0];
         got.pix = rsp_tdata[14:1];
         got.colour = rsp_tdata[22:15];
         if (pending_writes.size() == 0) begin
            $display("%0t unexpected result wv=%0d pix=%0d colour=%0d",
                     $time, got.wv, got.pix, got.colour);
            errors++;
         end else begin
            want = pending_writes.pop_front();
            bad = 0;
            if (got.wv !== want.wv) begin
               $display("%0t write_valid expected %0d actual %0d", $time, want.wv, got.wv);
               bad = 1;
            end
            if (got.pix !== want.pix) begin
               $display("%0t pixel_address expected %0d actual %0d", $time, want.pix, got.pix);
               bad = 1;
            end
            if (got.colour !== want.colour) begin
               $display("%0t colour_index expected %0d actual %0d",
                        $time, want.colour, got.colour);
               bad = 1;
            end
            if (bad) errors++;
         end
      end
   end

   initial begin
      @(posedge clock iff hold_go);
      hold <= 1;
      repeat (400) @(posedge clock);
      hold <= 0;
   end

   initial begin
      #20_000_000;
      $display("[indexed_zbuffer_point_plotter_core] ERROR");
      $finish;
   end

   task automatic send(point_op_t op, bit typed, pixel_write_t want);
      int gap;
      pixel_write_t w;
      gap = 0;
      while (gap < 50 && $urandom_range(99) < send_idle) gap++;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= REQ_DATA_W'({op.load_data, op.load_addr, op.tex_v, op.tex_u, op.inten,
                                op.depth, op.pos_y, op.pos_x, op.cmd});
      do @(posedge clock); while (!req_tready);
      w = plot_point(op);
      pending_writes.push_back(typed ? want : w);
   endtask

   task automatic send_checked(point_op_t op);
      send(op, 0, '{1'b0, 14'd0, 8'd0});
   endtask

   task automatic send_load(cmd_type cmd, logic [13:0] addr, logic [7:0] data);
      point_op_t op;
      op = '{cmd, 12'($urandom), 12'($urandom), 16'($urandom), 8'($urandom),
             32'($urandom), 32'($urandom), addr, data};
      send_checked(op);
   endtask

   // load whatever stores this plot will read that hold nothing yet
   task automatic prep_plot(point_op_t op);
      logic [13:0] pix;
      logic [11:0] ti;
      logic [13:0] si;
      pix = pixel_of(op);
      if (!depth_known[pix]) send_load(CMD_CLEAR_DEPTH, pix, 8'($urandom));
      if (cur_mode != MODE_FLAT) begin
         ti = texel_of(op);
         if (!texel_known[ti])
            send_load(CMD_LOAD_TEXEL, {2'($urandom), ti},
                      $urandom_range(5) == 0 ? 8'd0 : 8'($urandom));
         if (cur_mode[1] && texel_mem[ti] != 0) begin
            si = shade_of(op, texel_mem[ti]);
            if (!shade_known[si]) send_load(CMD_LOAD_SHADE, si, 8'($urandom));
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [7:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_RENDER_MODE: cur_mode = val[1:0];
         CSR_TEX_WIDTH: cur_tw = val[6:0];
         default: cur_th = val[6:0];
      endcase
      @(posedge clock);
   endtask

   task automatic configure(logic [7:0] mode, logic [7:0] tw, logic [7:0] th);
      drain();
      write_csr(CSR_RENDER_MODE, mode);
      write_csr(CSR_TEX_WIDTH, tw);
      write_csr(CSR_TEX_HEIGHT, th);
   endtask

   function automatic void add_row(logic [1:0] mode, logic [6:0] tw, logic [6:0] th,
                                   cmd_type cmd, int x, int y, int depth, int inten,
                                   int u, int v, int addr, int data,
                                   bit typed, int wv, int pix, int colour);
      dir_row_t r;
      r.mode = mode;
      r.tw = tw;
      r.th = th;
      r.op = '{cmd, 12'(x), 12'(y), 16'(depth), 8'(inten), 32'(u), 32'(v), 14'(addr),
               8'(data)};
      r.typed = typed;
      r.want = '{1'(wv), 14'(pix), 8'(colour)};
      rows.push_back(r);
   endfunction

   function automatic int coord_pick();
      int r;
      r = $urandom_range(9);
      if (r < 4) return $urandom_range(7);
      if (r < 8) return $urandom_range(127);
      return int'(12'($urandom));
   endfunction

   function automatic logic [7:0] size_pick();
      case ($urandom_range(6))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd64;
         3: return 8'd65;
         4: return 8'($urandom);
         default: return 8'($urandom_range(1, 64));
      endcase
   endfunction

   initial begin
      point_op_t op;
      int kind;
      add_row(MODE_FLAT, 64, 64, CMD_CLEAR_DEPTH, 0, 0, 0, 0, 0, 0, 16256, 0, 1, 0, 0, 0);
      add_row(MODE_FLAT, 64, 64, CMD_PLOT, -2048, 2047, 16'h1234, 255, 0, 0, 0, 0,
              1, 1, 16256, 255);
      add_row(MODE_FLAT, 64, 64, CMD_PLOT, -1, 2047, 16'h1234, 7, 0, 0, 0, 0,
              1, 0, 16256, 0);
      add_row(MODE_FLAT, 64, 64, CMD_PLOT, -5, 200, 0, 0, 0, 0, 0, 0, 1, 1, 16256, 0);
      add_row(MODE_FLAT, 64, 64, CMD_CLEAR_DEPTH, 0, 0, 0, 0, 0, 0, 127, 255, 1, 0, 0, 0);
      add_row(MODE_FLAT, 64, 64, CMD_PLOT, 2047, -2048, 16'hFFFF, 9, 0, 0, 0, 0,
              1, 0, 127, 0);
      add_row(MODE_FLAT, 64, 64, CMD_PLOT, 2047, -2048, 16'hFFFE, 128, 0, 0, 0, 0,
              1, 1, 127, 128);
      add_row(MODE_FLAT, 64, 64, CMD_LOAD_SHADE, 0, 0, 0, 0, 0, 0, 16383, 255, 1, 0, 0, 0);
      add_row(MODE_FLAT, 64, 64, CMD_LOAD_TEXEL, 0, 0, 0, 0, 0, 0, 16383, 8'h5A, 1, 0, 0, 0);
      add_row(MODE_TEXTURED, 64, 64, CMD_LOAD_TEXEL, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(MODE_TEXTURED, 64, 64, CMD_CLEAR_DEPTH, 0, 0, 0, 0, 0, 0, 645, 0, 1, 0, 0, 0);
      add_row(MODE_TEXTURED, 64, 64, CMD_PLOT, 5, 5, 100, 3, 0, 0, 0, 0, 1, 0, 645, 0);
      add_row(MODE_TEXTURED, 64, 64, CMD_PLOT, 5, 5, 100, 3, -65536, -1, 0, 0,
              1, 1, 645, 8'h5A);
      add_row(MODE_LIT_ALT, 64, 64, CMD_LOAD_SHADE, 0, 0, 0, 0, 0, 0, 16218, 8'hC3,
              1, 0, 0, 0);
      add_row(MODE_LIT_ALT, 64, 64, CMD_CLEAR_DEPTH, 0, 0, 0, 0, 0, 0, 646, 0, 1, 0, 0, 0);
      add_row(MODE_LIT_ALT, 64, 64, CMD_PLOT, 6, 5, 0, 255, -65536, -1, 0, 0,
              1, 1, 646, 8'hC3);
      add_row(MODE_LIT, 0, 72, CMD_PLOT, 7, 5, 50, 63, 32'h7FFFFFFF, 32'h80000000, 0, 0,
              0, 0, 0, 0);
      add_row(MODE_LIT, 1, 64, CMD_PLOT, 127, 127, 0, 64, 32'hFFFFFFFF, 32'h0003_8000, 0, 0,
              0, 0, 0, 0);
      add_row(MODE_TEXTURED, 64, 1, CMD_PLOT, 3, 127, 7, 1, 32'h003F_FFFF, 32'h7FFF0000,
              0, 0, 0, 0, 0, 0);
      add_row(MODE_FLAT, 64, 64, CMD_PLOT, 0, 0, 16'hFFFE, 8'hAA, 0, 0, 0, 0, 0, 0, 0, 0);

      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i]) begin
         if (rows[i].mode != cur_mode || rows[i].tw != cur_tw || rows[i].th != cur_th)
            configure(8'(rows[i].mode), 8'(rows[i].tw), 8'(rows[i].th));
         if (rows[i].op.cmd == CMD_PLOT && !rows[i].typed) prep_plot(rows[i].op);
         send(rows[i].op, rows[i].typed, rows[i].want);
      end

      for (int ph = 0; ph < 4; ph++) begin
         for (int blk = 0; blk < 2; blk++) begin
            drain();
            send_idle = (ph == 1) ? 65 : (ph == 3 ? 29 : 0);
            stall_pct = (ph == 2) ? 65 : (ph == 3 ? 29 : 0);
            configure(8'($urandom_range(3)) | (8'($urandom) & 8'hFC), size_pick(),
                      size_pick());
            if (ph == 0 && blk == 0) hold_go = 1;
            for (int n = 0; n < 70; n++) begin
               kind = $urandom_range(19);
               if (kind < 3) begin
                  send_load(CMD_CLEAR_DEPTH, $urandom_range(1) ?
                            14'($urandom_range(7) * SCR_W + $urandom_range(7)) :
                            14'($urandom), 8'($urandom));
               end else if (kind < 6) begin
                  send_load(CMD_LOAD_TEXEL, 14'($urandom),
                            $urandom_range(5) == 0 ? 8'd0 : 8'($urandom));
               end else if (kind < 8) begin
                  send_load(CMD_LOAD_SHADE, 14'($urandom), 8'($urandom));
               end else begin
                  op.cmd = CMD_PLOT;
                  op.pos_x = 12'(coord_pick());
                  op.pos_y = 12'(coord_pick());
                  op.depth = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(2000));
                  op.inten = 8'($urandom);
                  op.tex_u = 32'($urandom);
                  op.tex_v = $urandom_range(1) ? 32'($urandom)
                                               : 32'($urandom_range(1 << 22)) - (1 << 21);
                  op.load_addr = 14'($urandom);
                  op.load_data = 8'($urandom);
                  prep_plot(op);
                  send_checked(op);
               end
            end
         end
      end

      req_tvalid <= 0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("[indexed_zbuffer_point_plotter_core] OK");
      end else begin
         $display("[indexed_zbuffer_point_plotter_core] ERROR");
      end
      $finish;
   end

endmodule
